/* rtl/cbor_item_skipper_macros.svh */
// ----------------------------------------------------------------------------
// cbor_item_skipper_macros.svh
// Assertion macros for the CBOR item skipper; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef CBOR_ITEM_SKIPPER_MACROS_SVH
`define CBOR_ITEM_SKIPPER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle check
`define CIS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// antecedent this cycle, consequent next cycle
`define CIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CIS_ASSERT(lbl, prop, msg)
`define CIS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/cis_pkg.sv */
// ----------------------------------------------------------------------------
// cis_pkg
// Codes and types shared by the CBOR item skipper.
// ----------------------------------------------------------------------------
package cis_pkg;

	typedef logic [2:0] status_t;
	typedef logic [1:0] phase_t;
	typedef logic [2:0] major_t;

	// result status
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_TRUNC    = 3'd1;
	localparam status_t ST_RESERVED = 3'd2;
	localparam status_t ST_DEEP     = 3'd3;
	localparam status_t ST_OVER     = 3'd4;

	// parse phase
	localparam phase_t PH_HEAD = 2'd0;
	localparam phase_t PH_ARG  = 2'd1;
	localparam phase_t PH_PAY  = 2'd2;

	// major types that need more than their header
	localparam major_t MT_BSTR  = 3'd2;
	localparam major_t MT_TSTR  = 3'd3;
	localparam major_t MT_ARRAY = 3'd4;
	localparam major_t MT_MAP   = 3'd5;
	localparam major_t MT_TAG   = 3'd6;

	// header decode
	localparam logic [7:0] INFO_MASK   = 8'h1F;
	localparam logic [4:0] SHORT_MAX   = 5'd23;
	localparam int         MAJOR_SHIFT = 5;

	// one open container level
	typedef struct packed {
		logic [63:0] children;
		logic        value_pending;
		logic        is_map;
	} stack_entry_t;

endpackage

/* rtl/cbor_item_skipper.sv */
// ----------------------------------------------------------------------------
// cbor_item_skipper: walks one CBOR data item per result, one byte per beat
// while byte_stall is low. When a child ends under open levels, bytes stall
// while the stack is walked, one stack memory read per open level touched.
// The deciding byte or pop sets the result into the output register;
// a result that meets a stalled output holds off bytes until it moves out.
// arst_n clears control state only; the stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
`include "cbor_item_skipper_macros.svh"

module cbor_item_skipper
	import cis_pkg::*;
#(
	parameter int NEST_DEPTH  = 16,
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [31:0] item_length
);

	// level count holds 0..NEST_DEPTH; stack address covers the entries
	localparam int LW = $clog2(NEST_DEPTH + 1);
	localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	// byte counter is as wide as the length limit, at most 32 bits
	localparam int CW = (LENGTH_BITS >= 32) ? 32 : LENGTH_BITS;
	localparam logic [CW-1:0] LEN_LIMIT = {CW{1'b1}};

	// sequencer
	localparam logic [1:0] S_IDLE = 2'd0;  // take a byte
	localparam logic [1:0] S_POP  = 2'd1;  // stack top in stack_rd_q, finish a child
	localparam logic [1:0] S_HOLD = 2'd2;  // result waits for the output register

	logic [1:0]   state_q, state_d;

	// parse state
	phase_t       phase_q, phase_d;
	logic [3:0]   abl_q, abl_d;          // argument bytes left
	logic [63:0]  acc_q, acc_d;          // argument accumulator
	major_t       major_q, major_d;
	logic [CW-1:0] pay_q, pay_d;         // payload bytes left
	logic [LW-1:0] level_q, level_d;     // open container levels
	logic [CW-1:0] cons_q, cons_d;       // bytes consumed
	logic         last_q, last_d;        // byte under work was the last one

	// stack memory: one write port, one registered read port
	stack_entry_t stack_mem [NEST_DEPTH];
	stack_entry_t stack_rd_q;
	logic         mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	stack_entry_t mem_wdata;
	logic [LW-1:0] rd_level;
	logic [LW-1:0] top_level;

	// result
	logic         res_valid;
	status_t      res_status;
	logic [31:0]  res_len;
	status_t      hold_status_q;
	logic [31:0]  hold_len_q;
	logic         out_valid_q, out_valid_d;
	status_t      out_status_q;
	logic [31:0]  out_len_q;
	logic         slot_free;

	// byte decode
	logic         byte_acc;
	logic [4:0]   info;
	logic         do_hdone, do_leaf, pop_end;
	logic [63:0]  hd_arg, count, child_dec;
	logic [3:0]   abl_n;
	logic [CW-1:0] pay_n;

	assign byte_stall = (state_q != S_IDLE);
	assign byte_acc   = byte_valid && !byte_stall;
	assign info       = 5'(data_byte & INFO_MASK);
	assign slot_free  = !out_valid_q || !result_stall;
	assign child_dec  = stack_rd_q.children - 64'd1;
	// current stack top
	assign top_level  = level_q - LW'(1);

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		abl_d      = abl_q;
		acc_d      = acc_q;
		major_d    = major_q;
		pay_d      = pay_q;
		level_d    = level_q;
		cons_d     = cons_q;
		last_d     = last_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_len    = '0;
		do_hdone   = 1'b0;
		do_leaf    = 1'b0;
		pop_end    = 1'b0;
		hd_arg     = '0;
		count      = '0;
		abl_n      = '0;
		pay_n      = '0;

		case (state_q)
			S_IDLE: begin
				if (byte_acc) begin
					last_d = end_of_buffer;
					if (cons_q == LEN_LIMIT) begin
						// count saturated: byte is refused and not counted
						res_valid  = 1'b1;
						res_status = ST_OVER;
					end else begin
						cons_d = cons_q + CW'(1);
						case (phase_q)
							PH_HEAD: begin
								major_d = 3'(data_byte >> MAJOR_SHIFT);
								if (info <= SHORT_MAX) begin
									do_hdone = 1'b1;
									hd_arg   = 64'(info);
								end else if (info <= SHORT_MAX + 5'd4) begin
									// 1, 2, 4 or 8 argument bytes follow
									abl_d   = 4'd1 << info[1:0];
									acc_d   = '0;
									phase_d = PH_ARG;
								end else begin
									// reserved codes and indefinite lengths, break too
									res_valid  = 1'b1;
									res_status = ST_RESERVED;
								end
							end
							PH_ARG: begin
								acc_d = {acc_q[55:0], data_byte};
								abl_n = (abl_q != '0) ? abl_q - 4'd1 : abl_q;
								abl_d = abl_n;
								if (abl_n == '0) begin
									do_hdone = 1'b1;
									hd_arg   = acc_d;
								end
							end
							PH_PAY: begin
								pay_n = (pay_q != '0) ? pay_q - CW'(1) : pay_q;
								pay_d = pay_n;
								if (pay_n == '0) begin
									phase_d = PH_HEAD;
									do_leaf = 1'b1;
								end
							end
							default: begin
							end
						endcase

						// header complete: string, container or leaf
						if (do_hdone) begin
							phase_d = PH_HEAD;
							if (major_d inside {MT_BSTR, MT_TSTR}) begin
								if (hd_arg == '0) begin
									do_leaf = 1'b1;
								end else if (hd_arg > 64'(LEN_LIMIT - cons_d)) begin
									res_valid  = 1'b1;
									res_status = ST_OVER;
								end else begin
									pay_d   = hd_arg[CW-1:0];
									phase_d = PH_PAY;
								end
							end else if (major_d inside {MT_ARRAY, MT_MAP, MT_TAG}) begin
								count = (major_d == MT_TAG) ? 64'd1 : hd_arg;
								if (count == '0) begin
									do_leaf = 1'b1;
								end else if (level_q >= LW'(NEST_DEPTH)) begin
									res_valid  = 1'b1;
									res_status = ST_DEEP;
								end else begin
									// push a new open level
									mem_we                  = 1'b1;
									mem_waddr               = level_q[AW-1:0];
									mem_wdata.children      = count;
									mem_wdata.value_pending = 1'b0;
									mem_wdata.is_map        = (major_d == MT_MAP);
									level_d                 = level_q + LW'(1);
								end
							end else begin
								do_leaf = 1'b1;
							end
						end

						// child ended: top level item done, or walk the stack
						if (do_leaf) begin
							if (level_q == '0) begin
								res_valid  = 1'b1;
								res_status = ST_OK;
							end else begin
								mem_re  = 1'b1;
								state_d = S_POP;
							end
						end

						if (!res_valid && state_d == S_IDLE && end_of_buffer) begin
							res_valid  = 1'b1;
							res_status = ST_TRUNC;
						end
					end
					res_len = 32'(cons_d);
				end
			end
			S_POP: begin
				mem_waddr = top_level[AW-1:0];
				if (stack_rd_q.is_map && !stack_rd_q.value_pending) begin
					// key done, value still to come
					mem_we                  = 1'b1;
					mem_wdata               = stack_rd_q;
					mem_wdata.value_pending = 1'b1;
					pop_end                 = 1'b1;
				end else if (child_dec != '0) begin
					mem_we                  = 1'b1;
					mem_wdata.children      = child_dec;
					mem_wdata.value_pending = 1'b0;
					mem_wdata.is_map        = stack_rd_q.is_map;
					pop_end                 = 1'b1;
				end else begin
					// level finished: close it and finish a child of the parent
					level_d = level_q - LW'(1);
					if (level_d == '0) begin
						res_valid  = 1'b1;
						res_status = ST_OK;
						state_d    = S_IDLE;
					end else begin
						mem_re = 1'b1;
					end
				end
				if (pop_end) begin
					state_d = S_IDLE;
					if (last_q) begin
						res_valid  = 1'b1;
						res_status = ST_TRUNC;
					end
				end
				res_len = 32'(cons_q);
			end
			S_HOLD: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// any result starts a fresh item at the next byte
		if (res_valid) begin
			phase_d = PH_HEAD;
			abl_d   = '0;
			acc_d   = '0;
			major_d = '0;
			pay_d   = '0;
			level_d = '0;
			cons_d  = '0;
			if (!slot_free) begin
				state_d = S_HOLD;
			end
		end

		// output register
		if (res_valid && slot_free) begin
			out_valid_d = 1'b1;
		end else if (state_q == S_HOLD && slot_free) begin
			out_valid_d = 1'b1;
		end else if (!result_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// read the entry below the new level count
	assign rd_level  = level_d - LW'(1);
	assign mem_raddr = rd_level[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_HEAD;
			abl_q       <= '0;
			acc_q       <= '0;
			major_q     <= '0;
			pay_q       <= '0;
			level_q     <= '0;
			cons_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			abl_q       <= abl_d;
			acc_q       <= acc_d;
			major_q     <= major_d;
			pay_q       <= pay_d;
			level_q     <= level_d;
			cons_q      <= cons_d;
			last_q      <= last_d;
			out_valid_q <= out_valid_d;
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (res_valid && slot_free) begin
			out_status_q <= res_status;
			out_len_q    <= res_len;
		end else if (state_q == S_HOLD && slot_free) begin
			out_status_q <= hold_status_q;
			out_len_q    <= hold_len_q;
		end
		if (res_valid && !slot_free) begin
			hold_status_q <= res_status;
			hold_len_q    <= res_len;
		end
	end

	// stack memory; a read is only issued after any write to the
	// same entry has landed, so no bypass is needed
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			stack_rd_q <= stack_mem[mem_raddr];
		end
	end

	assign result_valid = out_valid_q;
	assign status       = out_status_q;
	assign item_length  = out_len_q;

	`CIS_ASSERT(a_rw_apart, (mem_we && mem_re) |-> (mem_waddr != mem_raddr),
		"stack read and write hit one entry")
	`CIS_ASSERT(a_pop_level, (state_q == S_POP) |-> (level_q != '0),
		"stack walk with no open level")
	`CIS_ASSERT(a_level_max, level_q <= LW'(NEST_DEPTH), "open levels exceed stack depth")
	`CIS_ASSERT(a_pay_left, (phase_q == PH_PAY) |-> (pay_q != '0),
		"payload phase with nothing left")
	`CIS_ASSERT_NEXT(a_hold_drain, (state_q == S_HOLD) && !result_stall,
		(state_q == S_IDLE) && out_valid_q, "held result not moved to output")

endmodule
